// ===== rtl/core/eased_position_move_controller_core_assert.svh =====
// Assertion macros used by the core module.
`ifndef EASED_POSITION_MOVE_CONTROLLER_CORE_ASSERT_SVH
`define EASED_POSITION_MOVE_CONTROLLER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define EPMC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("eased position move controller check failed");
`define EPMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("eased position move controller check failed");
`else
`define EPMC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define EPMC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/epmc_pkg.sv =====
`default_nettype none
package epmc_pkg;

    localparam int POSITION_BITS = 24;
    localparam int REQ_BITS = 2;
    localparam int SPEED_BITS = 8;
    localparam int PROD_BITS = 2 * POSITION_BITS;
    localparam int DIV_CNT_BITS = $clog2(PROD_BITS);
    localparam int IN_FIELD_BITS = 2 * POSITION_BITS;
    localparam int IN_TDATA_BITS = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = SPEED_BITS + 3;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [REQ_BITS-1:0] REQ_TICK = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_ABS  = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_REL  = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOWER = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UPPER = 1'b1;

    localparam logic [SPEED_BITS-1:0] SPEED_MAX  = 8'd255;
    localparam logic [SPEED_BITS-1:0] SPEED_BASE = 8'd100;
    localparam logic [SPEED_BITS-1:0] EASE_SAT   = SPEED_MAX - SPEED_BASE;

    localparam logic [POSITION_BITS-1:0] UPPER_RESET = {1'b0, {(POSITION_BITS-1){1'b1}}};

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage
`default_nettype wire

// ===== rtl/core/epmc_div.sv =====
`default_nettype none
module epmc_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [epmc_pkg::PROD_BITS-1:0]      i_dividend,
    input  logic [epmc_pkg::POSITION_BITS-1:0]  i_divisor,
    output logic [epmc_pkg::PROD_BITS-1:0]      o_quotient,
    output epmc_pkg::t_div_status               o_status
);
    import epmc_pkg::*;

    logic [POSITION_BITS:0]   r_rem;
    logic [PROD_BITS-1:0]     r_quo;
    logic [POSITION_BITS-1:0] r_divisor;
    logic [DIV_CNT_BITS-1:0]  r_cnt;
    logic                     r_busy;
    logic                     r_done;

    logic [POSITION_BITS:0]   w_trial;
    logic                     w_fits;

    assign w_trial = {r_rem[POSITION_BITS-1:0], r_quo[PROD_BITS-1]};
    assign w_fits  = (w_trial >= {1'b0, r_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_BITS'(PROD_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_quo     <= i_dividend;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fits ? (w_trial - {1'b0, r_divisor}) : w_trial;
            r_quo <= {r_quo[PROD_BITS-2:0], w_fits};
        end
    end

    assign o_quotient    = r_quo;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

endmodule
`default_nettype wire

// ===== rtl/core/eased_position_move_controller_core.sv =====
// Channel     Direction  Payload (lowest bit first)
// s_axis      in         tdata: position, target_value; tuser: req_type
// m_axis      out        tdata: drive_speed, drive_retract, moving, arrived
// cfg write   in         index 0 lower_limit, index 1 upper_limit
//
// A moving tick steps through S_EVAL, S_MUL, S_DSTART, 48 divider steps in S_DIV,
// one quotient bit each, and S_DONE; the next item is taken back in S_IDLE.
// A tick whose goal equals its start skips the divider, going from S_MUL to
// S_DONE; every other item goes from S_EVAL straight to S_DONE.
// Reset is synchronous and active low; no clearing pass is needed.
// A result waits in the output register while m_axis_tready is low; the next item
// is still taken, and it holds in its final step until the register is free.
`default_nettype none
`include "eased_position_move_controller_core_assert.svh"
module eased_position_move_controller_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [epmc_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  logic [epmc_pkg::POSITION_BITS-1:0]     i_cfg_wdata,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // position, target_value
    input  logic [epmc_pkg::IN_TDATA_BITS-1:0]     s_axis_tdata,
    // req_type
    input  logic [epmc_pkg::REQ_BITS-1:0]          s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // drive_speed, drive_retract, moving, arrived
    output logic [epmc_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata
);
    import epmc_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EVAL   = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_DSTART = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    localparam int P = POSITION_BITS;

    logic [2:0]                  r_state;
    logic signed [P-1:0]         r_lower;
    logic signed [P-1:0]         r_upper;
    logic                        r_mode;
    logic signed [P-1:0]         r_goal;
    logic signed [P-1:0]         r_start;
    logic [SPEED_BITS-1:0]       r_speed;
    logic                        r_retract;
    logic                        r_arrived;
    logic [REQ_BITS-1:0]         r_req;
    logic signed [P-1:0]         r_pos;
    logic signed [P-1:0]         r_val;
    logic [P-1:0]                r_a;
    logic [P-1:0]                r_b;
    logic [P-1:0]                r_d;
    logic [PROD_BITS-1:0]        r_prod;
    logic                        r_out_valid;
    logic [OUT_TDATA_BITS-1:0]   r_out_data;

    logic signed [P:0]           w_pos_x;
    logic signed [P:0]           w_start_x;
    logic signed [P:0]           w_goal_x;
    logic signed [P:0]           w_lower_x;
    logic signed [P:0]           w_upper_x;
    logic signed [P:0]           w_diff_a;
    logic signed [P:0]           w_diff_b;
    logic signed [P:0]           w_diff_d;
    logic signed [P:0]           w_cand;
    logic signed [P:0]           w_low_clip;
    logic signed [P:0]           w_clamped;
    logic                        w_in_acc;
    logic                        w_out_free;
    logic [PROD_BITS-1:0]        w_quo;
    t_div_status                 w_div_status;

    function automatic logic [P-1:0] f_mag(input logic signed [P:0] x);
        logic signed [P:0] m;
        m = x[P] ? -x : x;
        return m[P-1:0];
    endfunction

    assign w_pos_x   = {r_pos[P-1], r_pos};
    assign w_start_x = {r_start[P-1], r_start};
    assign w_goal_x  = {r_goal[P-1], r_goal};
    assign w_lower_x = {r_lower[P-1], r_lower};
    assign w_upper_x = {r_upper[P-1], r_upper};
    assign w_diff_a  = w_pos_x - w_start_x;
    assign w_diff_b  = w_pos_x - w_goal_x;
    assign w_diff_d  = w_goal_x - w_start_x;

    assign w_cand     = (r_req == REQ_ABS) ? {r_val[P-1], r_val}
                                           : (w_pos_x + {r_val[P-1], r_val});
    assign w_low_clip = (w_cand < w_upper_x) ? w_cand : w_upper_x;
    assign w_clamped  = (w_low_clip > w_lower_x) ? w_low_clip : w_lower_x;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    epmc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DSTART),
        .i_dividend (r_prod),
        .i_divisor  (r_d),
        .o_quotient (w_quo),
        .o_status   (w_div_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= '0;
        end else if (i_cfg_we && i_cfg_index == CFG_LOWER) begin
            r_lower <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper <= UPPER_RESET;
        end else if (i_cfg_we && i_cfg_index == CFG_UPPER) begin
            r_upper <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_req <= s_axis_tuser;
            r_pos <= s_axis_tdata[P-1:0];
            r_val <= s_axis_tdata[2*P-1:P];
        end
        if (r_state == S_EVAL) begin
            r_a <= f_mag(w_diff_a);
            r_b <= f_mag(w_diff_b);
            r_d <= f_mag(w_diff_d);
        end
        if (r_state == S_MUL) begin
            r_prod <= {{P{1'b0}}, r_a} * {{P{1'b0}}, r_b};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= 1'b0;
            r_goal      <= '0;
            r_start     <= '0;
            r_speed     <= '0;
            r_retract   <= 1'b0;
            r_arrived   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_arrived <= (r_req == REQ_TICK) && r_mode && (r_pos == r_goal);
                    if (r_req == REQ_ABS || r_req == REQ_REL) begin
                        r_mode  <= 1'b1;
                        r_start <= r_pos;
                        r_goal  <= w_clamped[P-1:0];
                        r_state <= S_DONE;
                    end else if (r_req == REQ_TICK && r_mode) begin
                        if (r_pos == r_goal) begin
                            r_mode    <= 1'b0;
                            r_goal    <= '0;
                            r_start   <= '0;
                            r_speed   <= '0;
                            r_state   <= S_DONE;
                        end else begin
                            r_retract <= (r_goal < r_start);
                            r_state   <= S_MUL;
                        end
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_MUL: begin
                    if (r_d == '0) begin
                        r_speed <= SPEED_BASE;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DSTART;
                    end
                end
                S_DSTART: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_status.done) begin
                        if (w_quo >= PROD_BITS'(EASE_SAT)) begin
                            r_speed <= SPEED_MAX;
                        end else begin
                            r_speed <= w_quo[SPEED_BITS-1:0] + SPEED_BASE;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_data <= {{(OUT_TDATA_BITS-OUT_FIELD_BITS){1'b0}},
                           r_arrived, r_mode, r_retract, r_speed};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `EPMC_ASSERT_NEXT(a_accept_eval, i_clk, i_rst_n, w_in_acc, r_state == S_EVAL)
    `EPMC_ASSERT_IMPL(a_idle_stopped, i_clk, i_rst_n, !r_mode, r_speed == '0)
    `EPMC_ASSERT_IMPL(a_done_in_div, i_clk, i_rst_n, w_div_status.done, r_state == S_DIV)
    `EPMC_ASSERT_IMPL(a_div_running, i_clk, i_rst_n, r_state == S_DIV, w_div_status.busy || w_div_status.done)

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
module testbench;
    import epmc_pkg::*;

    localparam logic [REQ_BITS-1:0] REQ_NONE = 2'd3;
    localparam int SETTLE_CYCLES = 60;
    localparam int BLOCK_ITEMS = 120;
    localparam int LIMIT_SETTINGS = 10;

    typedef logic signed [POSITION_BITS-1:0] t_pos;

    typedef struct packed {
        logic [SPEED_BITS-1:0] speed;
        logic retract;
        logic moving;
        logic arrived;
    } t_drive;

    typedef struct {
        bit is_cfg;
        logic [CFG_INDEX_BITS-1:0] index;
        logic [REQ_BITS-1:0] req;
        t_pos pos;
        t_pos val;
    } t_pending;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [POSITION_BITS-1:0] i_cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_BITS-1:0] s_axis_tdata = '0;
    logic [REQ_BITS-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;

    eased_position_move_controller_core DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_pending req_q[$];
    t_drive exp_drive_q[$];

    // Predicted controller state.
    longint lim_lower = 0;
    longint lim_upper = 64'sd8388607;
    bit mv_active = 1'b0;
    longint mv_goal = 0;
    longint mv_start = 0;
    logic [SPEED_BITS-1:0] hold_speed = '0;
    logic hold_retract = 1'b0;

    // Limits as seen by the stimulus generator while it fills the queue.
    longint gen_lo = 0;
    longint gen_hi = 64'sd8388607;
    int made = 0;

    int err_count = 0;
    int items_done = 0;
    int limit_writes = 0;
    int arrivals = 0;
    int full_drives = 0;
    int eased_drives = 0;

    function automatic longint clamp_to(longint x, longint lo, longint hi);
        longint t;
        t = (x < hi) ? x : hi;
        return (t > lo) ? t : lo;
    endfunction

    function automatic logic [SPEED_BITS-1:0] eased_speed(longint pos);
        longint a, b, d, e;
        a = pos - mv_start;
        b = pos - mv_goal;
        d = mv_goal - mv_start;
        if (a < 0) a = -a;
        if (b < 0) b = -b;
        if (d < 0) d = -d;
        if (d == 0) return SPEED_BASE;
        e = (a * b) / d;
        if (e >= longint'(EASE_SAT)) return SPEED_MAX;
        return SPEED_BASE + e[SPEED_BITS-1:0];
    endfunction

    function automatic t_drive predict_drive(logic [REQ_BITS-1:0] req, t_pos pos, t_pos val);
        t_drive r;
        r.arrived = 1'b0;
        if (req == REQ_ABS || req == REQ_REL) begin
            mv_active = 1'b1;
            mv_start = pos;
            mv_goal = clamp_to(req == REQ_ABS ? longint'(val) : longint'(pos) + longint'(val),
                               lim_lower, lim_upper);
        end else if (req == REQ_TICK && mv_active) begin
            if (longint'(pos) == mv_goal) begin
                mv_goal = 0;
                mv_start = 0;
                mv_active = 1'b0;
                hold_speed = '0;
                r.arrived = 1'b1;
            end else begin
                hold_speed = eased_speed(pos);
                hold_retract = mv_goal < mv_start;
            end
        end
        r.speed = hold_speed;
        r.retract = hold_retract;
        r.moving = mv_active;
        return r;
    endfunction

    function automatic int draw_idle(bit calm);
        return calm ? 0 : int'($urandom_range(0, 19));
    endfunction

    function automatic longint near_step();
        if ($urandom_range(0, 7) == 0) return longint'($urandom_range(0, 20000)) - 10000;
        return longint'($urandom_range(0, 600)) - 300;
    endfunction

    function automatic t_pos rand_pos();
        longint base;
        case ($urandom_range(0, 4))
            0: base = gen_lo;
            1: base = gen_hi;
            2: base = 0;
            default: base = longint'(t_pos'($urandom));
        endcase
        return t_pos'(base + near_step());
    endfunction

    task automatic add_item(logic [REQ_BITS-1:0] req, t_pos pos, t_pos val);
        t_pending p;
        p.is_cfg = 1'b0;
        p.index = '0;
        p.req = req;
        p.pos = pos;
        p.val = val;
        req_q.push_back(p);
        if (req != REQ_NONE) made++;
    endtask

    task automatic add_cfg(logic [CFG_INDEX_BITS-1:0] index, t_pos value);
        t_pending p;
        p.is_cfg = 1'b1;
        p.index = index;
        p.req = REQ_TICK;
        p.pos = '0;
        p.val = value;
        req_q.push_back(p);
        if (index == CFG_LOWER) gen_lo = value;
        else gen_hi = value;
    endtask

    // A set request followed by ticks that walk toward the goal, mostly ending on it.
    task automatic add_move();
        t_pos start;
        t_pos tgt;
        longint goal;
        int n;
        int r;
        start = rand_pos();
        if ($urandom_range(0, 1) == 0) begin
            tgt = ($urandom_range(0, 3) == 0) ? rand_pos() : t_pos'(longint'(start) + near_step());
            add_item(REQ_ABS, start, tgt);
            goal = clamp_to(tgt, gen_lo, gen_hi);
        end else begin
            tgt = ($urandom_range(0, 7) == 0) ? t_pos'($urandom) : t_pos'(near_step());
            add_item(REQ_REL, start, tgt);
            goal = clamp_to(longint'(start) + longint'(tgt), gen_lo, gen_hi);
        end
        n = $urandom_range(1, 10);
        for (int k = 1; k < n; k++) begin
            r = $urandom_range(0, 15);
            if (r == 0) add_item(REQ_NONE, rand_pos(), t_pos'($urandom));
            else if (r == 1) add_item(REQ_TICK, t_pos'($urandom), t_pos'($urandom));
            else add_item(REQ_TICK,
                          t_pos'(longint'(start) + (goal - longint'(start)) * k / n
                                 + longint'($urandom_range(0, 6)) - 3),
                          t_pos'($urandom));
        end
        if ($urandom_range(0, 9) != 0) add_item(REQ_TICK, t_pos'(goal), t_pos'($urandom));
    endtask

    // Driver: presents queued items, and writes limits only once the block is idle.
    bit calm_src = 1'b0;
    int gap_left = 0;
    int quiet = 0;
    t_pending on_bus;

    always @(posedge i_clk) begin
        logic nxt_valid;
        logic nxt_we;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            i_cfg_we <= 1'b0;
        end else begin
            nxt_valid = s_axis_tvalid;
            nxt_we = 1'b0;
            if (s_axis_tvalid && s_axis_tready) begin
                exp_drive_q.push_back(predict_drive(on_bus.req, on_bus.pos, on_bus.val));
                items_done++;
                nxt_valid = 1'b0;
                if ($urandom_range(0, 39) == 0) calm_src = !calm_src;
                gap_left = draw_idle(calm_src);
            end
            quiet = (exp_drive_q.size() == 0 && !nxt_valid) ? quiet + 1 : 0;
            if (!nxt_valid && req_q.size() != 0) begin
                if (req_q[0].is_cfg) begin
                    if (quiet >= SETTLE_CYCLES) begin
                        on_bus = req_q.pop_front();
                        if (on_bus.index == CFG_LOWER) lim_lower = on_bus.val;
                        else lim_upper = on_bus.val;
                        i_cfg_index <= on_bus.index;
                        i_cfg_wdata <= on_bus.val;
                        nxt_we = 1'b1;
                        limit_writes++;
                    end
                end else if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    on_bus = req_q.pop_front();
                    s_axis_tdata <= IN_TDATA_BITS'({on_bus.val, on_bus.pos});
                    s_axis_tuser <= on_bus.req;
                    nxt_valid = 1'b1;
                end
            end
            s_axis_tvalid <= nxt_valid;
            i_cfg_we <= nxt_we;
        end
    end

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            err_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Monitor: takes results with random stalls and checks them in order.
    bit calm_snk = 1'b0;
    int stall_left = 0;

    always @(posedge i_clk) begin
        t_drive got;
        t_drive want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.speed = m_axis_tdata[7:0];
                got.retract = m_axis_tdata[8];
                got.moving = m_axis_tdata[9];
                got.arrived = m_axis_tdata[10];
                if (exp_drive_q.size() == 0) begin
                    err_count++;
                    $error("result with no item waiting: tdata %0h", m_axis_tdata);
                end else begin
                    want = exp_drive_q.pop_front();
                    check_field("drive_speed", want.speed, got.speed);
                    check_field("drive_retract", want.retract, got.retract);
                    check_field("moving", want.moving, got.moving);
                    check_field("arrived", want.arrived, got.arrived);
                    if (want.arrived) arrivals++;
                    else if (want.speed == SPEED_MAX) full_drives++;
                    else if (want.speed != '0) eased_drives++;
                end
                if ($urandom_range(0, 39) == 0) calm_snk = !calm_snk;
                stall_left = draw_idle(calm_snk);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        longint lo_plan [6] = '{-64'sd8388608, -1000, 500, 64'sd8388607, -64'sd8388608, 0};
        longint hi_plan [6] = '{64'sd8388607, 1000, -500, 64'sd8388607, -64'sd8388608, 300};
        t_pos lo;
        t_pos hi;

        // Idle tick, unused type, an eased move with arrival, a clamped goal on the
        // start (zero divisor), a retracting move with a huge product, a retarget,
        // relative moves past both ends, and a full-range move.
        add_item(REQ_TICK, 0, 0);
        add_item(REQ_NONE, -8388608, 8388607);
        add_item(REQ_ABS, 0, 1000);
        add_item(REQ_TICK, 0, 0);
        add_item(REQ_TICK, 500, 0);
        add_item(REQ_TICK, 990, 0);
        add_item(REQ_NONE, 990, -1);
        add_item(REQ_TICK, 1000, 0);
        add_item(REQ_ABS, 0, -5);
        add_item(REQ_TICK, 3, 0);
        add_item(REQ_TICK, 0, 0);
        add_item(REQ_REL, 300, -200);
        add_item(REQ_TICK, 250, 0);
        add_item(REQ_TICK, -8388608, 0);
        add_item(REQ_ABS, 120, 100);
        add_item(REQ_TICK, 100, 0);
        add_item(REQ_REL, 8388607, 8388607);
        add_item(REQ_TICK, 8388607, 0);
        add_item(REQ_REL, -8388608, -8388608);
        add_item(REQ_TICK, -8388608, 8388607);
        add_item(REQ_ABS, -8388608, 8388607);
        add_item(REQ_TICK, 0, 0);
        add_item(REQ_TICK, 8388607, -8388608);
        add_item(REQ_TICK, 8388607, 0);

        for (int s = 0; s < LIMIT_SETTINGS; s++) begin
            if (s < 6) begin
                lo = t_pos'(lo_plan[s]);
                hi = t_pos'(hi_plan[s]);
            end else begin
                lo = t_pos'($urandom);
                hi = ($urandom_range(0, 3) == 0) ? t_pos'($urandom)
                                                 : t_pos'(longint'(lo) + $urandom_range(0, 3000));
            end
            add_cfg(CFG_LOWER, lo);
            add_cfg(CFG_UPPER, hi);
            made = 0;
            while (made < BLOCK_ITEMS) begin
                if ($urandom_range(0, 4) == 0)
                    add_item(REQ_BITS'($urandom_range(0, 3)), t_pos'($urandom), t_pos'($urandom));
                else
                    add_move();
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_q.size() != 0 || s_axis_tvalid || exp_drive_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("summary: %0d items over %0d limit writes; %0d arrivals,",
                 items_done, limit_writes, arrivals);
        $display("summary: %0d eased drives, %0d at full speed, %0d mismatches",
                 eased_drives, full_drives, err_count);
        if (err_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("testbench: errors");
        $finish;
    end

endmodule
